// ----- src/tle_pkg.sv -----
// Package: shared types, operation codes and character constants for the line editor.
`timescale 1ns / 1ps
package tle_pkg;

	localparam int MAX_CHARS_DEF = 26;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_READ = 2'd1,
		OP_ACK  = 2'd2
	} op_t;

	localparam logic [7:0] CH_BEL   = 8'd7;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_HT    = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic DEST_TERM = 1'b0;
	localparam logic DEST_MSG  = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] in_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       destination;
		logic       last;
	} rsp_t;

endpackage

// ----- src/terminal_line_editor_with_echo_core.sv -----
// Top level: terminal line editor with echo, line held in a synchronous RAM.
//
//  channel   ports                       handshake
//  -------   -------------------------   -----------------------------------
//  request   start, busy, request        taken at a clock edge with start=1, busy=0
//  result    result_strobe, result       one byte per strobe cycle, no back-pressure
//
// A request with one result or none leaves busy low.
// An echo of CR LF or of BS space BS is emitted one byte per cycle.
// A readout emits the sequence byte, then one stored byte per cycle streamed
// from the registered RAM read port.
// Reset clears all control state; the RAM contents are not cleared.
`timescale 1ns / 1ps
module terminal_line_editor_with_echo_core #(
	parameter int MAX_CHARS = tle_pkg::MAX_CHARS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  tle_pkg::req_t request,
	output logic          result_strobe,
	output tle_pkg::rsp_t result
);

	localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int CW = $clog2(MAX_CHARS + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_CHARS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ECHO = 3'b010,
		ST_READ = 3'b100
	} state_t;

	state_t        state_q;
	logic          running_q;
	logic          pending_q;
	logic [CW-1:0] count_q;
	logic [7:0]    seq_q;
	logic [CW-1:0] rd_idx_q;
	logic          echo_bs_q;
	logic          echo_step_q;
	logic          strobe_q;
	tle_pkg::rsp_t rsp_q;

	logic          accept;
	logic          is_crlf;
	logic          is_bs;
	logic          is_full;
	logic          store;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign busy          = (state_q != ST_IDLE);
	assign accept        = start && !busy;
	assign result_strobe = strobe_q;
	assign result        = rsp_q;

	assign is_crlf = (request.in_byte == tle_pkg::CH_CR) || (request.in_byte == tle_pkg::CH_LF);
	assign is_bs   = (request.in_byte == tle_pkg::CH_BS);
	assign is_full = (count_q == FULL_COUNT);
	assign store   = accept && (request.operation == tle_pkg::OP_BYTE) && running_q
		&& !pending_q && !is_crlf && !is_bs && !is_full;

	// readout streams: address runs one ahead of the byte being emitted
	assign ram_raddr = (state_q == ST_READ) ? rd_idx_q[AW-1:0] : '0;

	tle_ram #(
		.WIDTH (8),
		.DEPTH (MAX_CHARS)
	) u_line_ram (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[AW-1:0]),
		.wdata (request.in_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			running_q   <= 1'b0;
			pending_q   <= 1'b0;
			count_q     <= '0;
			seq_q       <= '0;
			rd_idx_q    <= '0;
			echo_bs_q   <= 1'b0;
			echo_step_q <= 1'b0;
			strobe_q    <= 1'b0;
			rsp_q       <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (request.operation)
							tle_pkg::OP_BYTE: begin
								if (!running_q) begin
									if (request.in_byte == tle_pkg::CH_HT) begin
										running_q <= 1'b1;
									end else begin
										strobe_q <= 1'b1;
										rsp_q    <= '{tle_pkg::CH_BEL, tle_pkg::DEST_TERM, 1'b1};
									end
								end else if (pending_q) begin
									strobe_q <= 1'b1;
									rsp_q    <= '{tle_pkg::CH_BEL, tle_pkg::DEST_TERM, 1'b1};
								end else if (is_crlf) begin
									strobe_q <= 1'b1;
									if (count_q != '0) begin
										pending_q <= 1'b1;
										echo_bs_q <= 1'b0;
										state_q   <= ST_ECHO;
										rsp_q     <= '{tle_pkg::CH_CR, tle_pkg::DEST_TERM, 1'b0};
									end else begin
										rsp_q <= '{tle_pkg::CH_BEL, tle_pkg::DEST_TERM, 1'b1};
									end
								end else if (is_bs) begin
									strobe_q <= 1'b1;
									if (count_q != '0) begin
										count_q     <= count_q - CW'(1);
										echo_bs_q   <= 1'b1;
										echo_step_q <= 1'b0;
										state_q     <= ST_ECHO;
										rsp_q       <= '{tle_pkg::CH_BS, tle_pkg::DEST_TERM, 1'b0};
									end else begin
										rsp_q <= '{tle_pkg::CH_BEL, tle_pkg::DEST_TERM, 1'b1};
									end
								end else if (is_full) begin
									strobe_q <= 1'b1;
									rsp_q    <= '{tle_pkg::CH_BEL, tle_pkg::DEST_TERM, 1'b1};
								end else begin
									count_q  <= count_q + CW'(1);
									strobe_q <= 1'b1;
									rsp_q    <= '{request.in_byte, tle_pkg::DEST_TERM, 1'b1};
								end
							end
							tle_pkg::OP_READ: begin
								strobe_q <= 1'b1;
								rsp_q    <= '{seq_q, tle_pkg::DEST_MSG, (count_q == '0)};
								if (count_q != '0) begin
									rd_idx_q <= CW'(1);
									state_q  <= ST_READ;
								end
							end
							tle_pkg::OP_ACK: begin
								if (pending_q) begin
									pending_q <= 1'b0;
									count_q   <= '0;
									seq_q     <= seq_q + 8'd1;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_ECHO: begin
					strobe_q <= 1'b1;
					if (!echo_bs_q) begin
						rsp_q   <= '{tle_pkg::CH_LF, tle_pkg::DEST_TERM, 1'b1};
						state_q <= ST_IDLE;
					end else if (!echo_step_q) begin
						rsp_q       <= '{tle_pkg::CH_SPACE, tle_pkg::DEST_TERM, 1'b0};
						echo_step_q <= 1'b1;
					end else begin
						rsp_q   <= '{tle_pkg::CH_BS, tle_pkg::DEST_TERM, 1'b1};
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					// ram_rdata holds entry rd_idx_q-1
					strobe_q <= 1'b1;
					rsp_q    <= '{ram_rdata, tle_pkg::DEST_MSG, (rd_idx_q == count_q)};
					if (rd_idx_q == count_q) begin
						state_q <= ST_IDLE;
					end else begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/tle_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module tle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 26,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
